// File: sv/npz_pkg.sv
// Shared widths, constants and side-band types of the neutrino pz pipeline.
package npz_pkg;

   localparam int E_W          = 23;
   localparam int P_W          = 24;
   localparam int M_W          = 23;
   localparam int APP_W        = 51;
   localparam int APPM_W       = 50;
   localparam int A_W          = 48;
   localparam int AMAG_W       = 47;
   localparam int PT2_W        = 48;
   localparam int SQ_W         = 100;
   localparam int ROOT_W       = SQ_W / 2;
   localparam int SQRT_REM_W   = ROOT_W + 2;
   localparam int NB_W         = 73;
   localparam int NUM_W        = 73;
   localparam int D_W          = 48;
   localparam int QUO_W        = 24;
   localparam int SQRT_STAGES  = ROOT_W;
   localparam int DIV_STAGES   = QUO_W;
   localparam int REQ_TDATA_W  = 144;
   localparam int RSP_TDATA_W  = 24;
   localparam int CSR_TDATA_W  = 24;

   localparam logic [M_W-1:0]   W_MASS_RESET = 23'd20582;
   localparam logic [QUO_W-1:0] SAT_POS      = 24'h7FFFFF;
   localparam logic [QUO_W-1:0] SAT_NEG_MAG  = 24'h800000;

   typedef struct packed {
      logic [E_W-1:0]    e;
      logic [NB_W-1:0]   nb_mag;
      logic              nb_neg;
      logic [AMAG_W-1:0] a_mag;
      logic              a_neg;
      logic              a_zero;
      logic              cplx;
   } npz_root_side_type;

   typedef struct packed {
      logic num_neg;
      logic a_neg;
      logic a_zero;
      logic cplx;
      logic ovf;
   } npz_div_side_type;

endpackage

// File: sv/npz_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module npz_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [npz_pkg::SQ_W-1:0]     in_q,
   input  npz_pkg::npz_root_side_type   in_side,
   output logic                         out_valid,
   output logic [npz_pkg::ROOT_W-1:0]   out_root,
   output npz_pkg::npz_root_side_type   out_side
);

   localparam int N  = npz_pkg::SQRT_STAGES;
   localparam int RW = npz_pkg::SQRT_REM_W;
   localparam int SW = npz_pkg::ROOT_W;
   localparam int QW = npz_pkg::SQ_W;

   logic                       valid_ff [N];
   logic [RW-1:0]              rem_ff   [N];
   logic [SW-1:0]              root_ff  [N];
   logic [QW-1:0]              q_ff     [N];
   npz_pkg::npz_root_side_type side_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                       prev_valid;
      logic [RW-1:0]              prev_rem;
      logic [SW-1:0]              prev_root;
      logic [QW-1:0]              prev_q;
      npz_pkg::npz_root_side_type prev_side;
      logic [RW+1:0]              rem_wide;
      logic [RW+1:0]              trial;
      logic [RW-1:0]              rem_in;
      logic [SW-1:0]              root_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_q     = in_q;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_root  = root_ff[k-1];
         assign prev_q     = q_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      always_comb begin
         rem_wide = {prev_rem, prev_q[QW-1:QW-2]};
         trial    = {2'b00, prev_root, 2'b01};
         if (rem_wide >= trial) begin
            rem_in  = RW'(rem_wide - trial);
            root_in = {prev_root[SW-2:0], 1'b1};
         end else begin
            rem_in  = RW'(rem_wide);
            root_in = {prev_root[SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= prev_valid;
         end
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            q_ff[k]    <= {prev_q[QW-3:0], 2'b00};
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// File: sv/npz_div.sv
// Pipelined restoring division, one quotient bit per stage.
module npz_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [npz_pkg::NUM_W-1:0]   in_num,
   input  logic [npz_pkg::D_W-1:0]     in_d,
   input  npz_pkg::npz_div_side_type   in_side,
   output logic                        out_valid,
   output logic [npz_pkg::QUO_W-1:0]   out_quo,
   output npz_pkg::npz_div_side_type   out_side
);

   localparam int N  = npz_pkg::DIV_STAGES;
   localparam int DW = npz_pkg::D_W;
   localparam int QW = npz_pkg::QUO_W;

   logic                      valid_ff [N];
   logic [DW-1:0]             rem_ff   [N];
   logic [DW-1:0]             d_ff     [N];
   logic [QW-1:0]             low_ff   [N];
   logic [QW-1:0]             quo_ff   [N];
   npz_pkg::npz_div_side_type side_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                      prev_valid;
      logic [DW-1:0]             prev_rem;
      logic [DW-1:0]             prev_d;
      logic [QW-1:0]             prev_low;
      logic [QW-1:0]             prev_quo;
      npz_pkg::npz_div_side_type prev_side;
      logic [DW:0]               rem_wide;
      logic [DW-1:0]             rem_in;
      logic [QW-1:0]             quo_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_num[DW+QW-1:QW];
         assign prev_d     = in_d;
         assign prev_low   = in_num[QW-1:0];
         assign prev_quo   = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_d     = d_ff[k-1];
         assign prev_low   = low_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      always_comb begin
         rem_wide = {prev_rem, prev_low[QW-1]};
         if (rem_wide >= {1'b0, prev_d}) begin
            rem_in = DW'(rem_wide - {1'b0, prev_d});
            quo_in = {prev_quo[QW-2:0], 1'b1};
         end else begin
            rem_in = DW'(rem_wide);
            quo_in = {prev_quo[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= prev_valid;
         end
         if (enable) begin
            rem_ff[k]  <= rem_in;
            d_ff[k]    <= prev_d;
            low_ff[k]  <= {prev_low[QW-2:0], 1'b0};
            quo_ff[k]  <= quo_in;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quo   = quo_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// File: sv/neutrino_pz_from_w_mass_core.sv
// Top level: neutrino longitudinal momentum from the W-mass constraint.
//
//   Group   Direction  Handshake            Payload
//   req_    in         req_tvalid/tready    req_tdata: E, lepton px/py/pz, met px/py
//   rsp_    out        rsp_tvalid/tready    rsp_tdata: neutrino pz; rsp_tuser: complex flag
//   csr_    in         csr_tvalid/tready    csr_tdata: W mass
//
// One request is accepted per cycle while no held result stalls the pipeline.
// Each request passes through the 50-stage square root and the 24-stage divider.
// Reset clears all valid bits and sets the W mass to 20582.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module neutrino_pz_from_w_mass_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // E[22:0], lepton_px[46:23], lepton_py[70:47], lepton_pz[94:71],
   // met_px[118:95], met_py[142:119], zero[143]
   input  logic [npz_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // neutrino_pz[23:0]
   output logic [npz_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // complex_flag[0]
   output logic                              rsp_tuser,
   input  logic                              csr_tvalid,
   output logic                              csr_tready,
   // w_mass[22:0], zero[23]
   input  logic [npz_pkg::CSR_TDATA_W-1:0]   csr_tdata
);

   logic adv;

   logic [npz_pkg::M_W-1:0] w_mass_ff;

   logic        [npz_pkg::E_W-1:0] in_e;
   logic signed [npz_pkg::P_W-1:0] in_lx, in_ly, in_lz, in_nx, in_ny;

   logic                     s1_valid_ff;
   logic [45:0]              s1_ee_ff, s1_mm_ff, s1_ee_in, s1_mm_in;
   logic signed [47:0]       s1_zz_ff, s1_xx_ff, s1_yy_ff, s1_xn_ff, s1_yn_ff;
   logic signed [47:0]       s1_nxx_ff, s1_nyy_ff;
   logic signed [47:0]       s1_zz_in, s1_xx_in, s1_yy_in, s1_xn_in, s1_yn_in;
   logic signed [47:0]       s1_nxx_in, s1_nyy_in;
   logic signed [npz_pkg::P_W-1:0] s1_lz_ff;
   logic [npz_pkg::E_W-1:0]  s1_e_ff;

   logic                                s2_valid_ff;
   logic signed [npz_pkg::APP_W-1:0]    s2_pa_ff, s2_pb_ff, s2_pa_in, s2_pb_in;
   logic signed [npz_pkg::A_W-1:0]      s2_a_ff, s2_a_in;
   logic [npz_pkg::PT2_W-1:0]           s2_pt2_ff, s2_pt2_in;
   logic signed [npz_pkg::P_W-1:0]      s2_lz_ff;
   logic [npz_pkg::E_W-1:0]             s2_e_ff;

   logic                                s3_valid_ff;
   logic signed [npz_pkg::APP_W-1:0]    s3_app_ff;
   logic signed [npz_pkg::A_W-1:0]      s3_a_ff;
   logic [npz_pkg::PT2_W-1:0]           s3_pt2_ff;
   logic signed [npz_pkg::P_W-1:0]      s3_lz_ff;
   logic [npz_pkg::E_W-1:0]             s3_e_ff;

   logic                         s4_valid_ff;
   logic [npz_pkg::APPM_W-1:0]   s4_app_mag_ff, s4_app_mag_in;
   logic                         s4_app_neg_ff;
   logic [npz_pkg::AMAG_W-1:0]   s4_a_mag_ff, s4_a_mag_in;
   logic                         s4_a_neg_ff, s4_a_zero_ff;
   logic [npz_pkg::P_W-1:0]      s4_lz_mag_ff, s4_lz_mag_in;
   logic                         s4_lz_neg_ff;
   logic [npz_pkg::PT2_W-1:0]    s4_pt2_ff;
   logic [npz_pkg::E_W-1:0]      s4_e_ff;

   logic                         s5_valid_ff;
   logic [49:0]                  s5_sq_hh_ff, s5_sq_hl_ff, s5_sq_ll_ff;
   logic [47:0]                  s5_t_hh_ff, s5_t_hl_ff;
   logic [48:0]                  s5_t_lh_ff, s5_t_ll_ff;
   logic [48:0]                  s5_nb_h_ff, s5_nb_l_ff;
   logic [24:0]                  s5_h, s5_l, s5_al;
   logic [23:0]                  s5_ah, s5_ph, s5_pl;
   logic [48:0]                  s5_a4;
   logic                         s5_nb_sign_ff;
   logic [npz_pkg::AMAG_W-1:0]   s5_a_mag_ff;
   logic                         s5_a_neg_ff, s5_a_zero_ff;
   logic [npz_pkg::E_W-1:0]      s5_e_ff;

   logic                         s6_valid_ff;
   logic [npz_pkg::SQ_W-1:0]     s6_sq_ff, s6_t_ff, s6_sq_in, s6_t_in;
   logic [npz_pkg::NB_W-1:0]     s6_nb_ff, s6_nb_in;
   logic                         s6_nb_neg_ff;
   logic [npz_pkg::AMAG_W-1:0]   s6_a_mag_ff;
   logic                         s6_a_neg_ff, s6_a_zero_ff;
   logic [npz_pkg::E_W-1:0]      s6_e_ff;

   logic                         s7_valid_ff;
   logic [npz_pkg::SQ_W-1:0]     s7_q_ff, s7_q_in;
   npz_pkg::npz_root_side_type   s7_side_ff, s7_side_in;

   logic                         sq_valid;
   logic [npz_pkg::ROOT_W-1:0]   sq_root;
   npz_pkg::npz_root_side_type   sq_side;

   logic                         s8_valid_ff;
   logic [47:0]                  s8_term_h_ff, s8_term_l_ff;
   npz_pkg::npz_root_side_type   s8_side_ff;

   logic                         s9_valid_ff;
   logic [npz_pkg::NB_W-1:0]     s9_term_ff;
   npz_pkg::npz_root_side_type   s9_side_ff;

   logic                         s10_valid_ff;
   logic [npz_pkg::NB_W:0]       s10_diff;
   logic [npz_pkg::NUM_W-1:0]    s10_num_ff, s10_num_in;
   logic                         s10_num_neg_ff, s10_num_neg_in;
   logic [npz_pkg::D_W-1:0]      s10_d_ff;
   logic                         s10_a_neg_ff, s10_a_zero_ff, s10_cplx_ff;

   logic                         s11_valid_ff;
   logic [npz_pkg::NUM_W-1:0]    s11_num_ff;
   logic [npz_pkg::D_W-1:0]      s11_d_ff;
   npz_pkg::npz_div_side_type    s11_side_ff, s11_side_in;

   logic                         dv_valid;
   logic [npz_pkg::QUO_W-1:0]    dv_quo;
   npz_pkg::npz_div_side_type    dv_side;

   logic                         rsp_tvalid_ff;
   logic [npz_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                         rsp_tuser_ff, rsp_tuser_in;
   logic                         fin_neg;
   logic [npz_pkg::QUO_W-1:0]    fin_mag;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_mass_ff <= npz_pkg::W_MASS_RESET;
      end else if (csr_tvalid) begin
         w_mass_ff <= csr_tdata[npz_pkg::M_W-1:0];
      end
   end

   assign in_e  = req_tdata[22:0];
   assign in_lx = req_tdata[46:23];
   assign in_ly = req_tdata[70:47];
   assign in_lz = req_tdata[94:71];
   assign in_nx = req_tdata[118:95];
   assign in_ny = req_tdata[142:119];

   always_comb begin
      s1_ee_in  = {23'd0, in_e} * {23'd0, in_e};
      s1_mm_in  = {23'd0, w_mass_ff} * {23'd0, w_mass_ff};
      s1_zz_in  = in_lz * in_lz;
      s1_xx_in  = in_lx * in_lx;
      s1_yy_in  = in_ly * in_ly;
      s1_xn_in  = in_lx * in_nx;
      s1_yn_in  = in_ly * in_ny;
      s1_nxx_in = in_nx * in_nx;
      s1_nyy_in = in_ny * in_ny;
   end

   always_comb begin
      s2_pa_in  = $signed({5'd0, s1_ee_ff}) - $signed({{3{s1_zz_ff[47]}}, s1_zz_ff})
                - $signed({{3{s1_xx_ff[47]}}, s1_xx_ff})
                - $signed({{3{s1_yy_ff[47]}}, s1_yy_ff});
      s2_pb_in  = $signed({{2{s1_xn_ff[47]}}, s1_xn_ff, 1'b0})
                + $signed({{2{s1_yn_ff[47]}}, s1_yn_ff, 1'b0})
                + $signed({5'd0, s1_mm_ff});
      s2_a_in   = $signed({2'd0, s1_ee_ff}) - s1_zz_ff;
      s2_pt2_in = {1'b0, s1_nxx_ff[46:0]} + {1'b0, s1_nyy_ff[46:0]};
   end

   always_comb begin
      s4_app_mag_in = s3_app_ff[npz_pkg::APP_W-1] ? npz_pkg::APPM_W'(-s3_app_ff)
                                                   : npz_pkg::APPM_W'(s3_app_ff);
      s4_a_mag_in   = s3_a_ff[npz_pkg::A_W-1] ? npz_pkg::AMAG_W'(-s3_a_ff)
                                               : npz_pkg::AMAG_W'(s3_a_ff);
      s4_lz_mag_in  = s3_lz_ff[npz_pkg::P_W-1] ? npz_pkg::P_W'(-s3_lz_ff)
                                                : npz_pkg::P_W'(s3_lz_ff);
   end

   always_comb begin
      s5_h  = s4_app_mag_ff[49:25];
      s5_l  = s4_app_mag_ff[24:0];
      s5_a4 = {s4_a_mag_ff, 2'b00};
      s5_ah = s5_a4[48:25];
      s5_al = s5_a4[24:0];
      s5_ph = s4_pt2_ff[47:24];
      s5_pl = s4_pt2_ff[23:0];
   end

   always_comb begin
      s6_sq_in = {s5_sq_hh_ff, 50'd0} + {24'd0, s5_sq_hl_ff, 26'd0} + {50'd0, s5_sq_ll_ff};
      s6_t_in  = {3'd0, s5_t_hh_ff, 49'd0} + {27'd0, s5_t_hl_ff, 25'd0}
               + {27'd0, s5_t_lh_ff, 24'd0} + {51'd0, s5_t_ll_ff};
      s6_nb_in = {s5_nb_h_ff[47:0], 25'd0} + {24'd0, s5_nb_l_ff};
   end

   always_comb begin
      s7_side_in.e      = s6_e_ff;
      s7_side_in.nb_mag = s6_nb_ff;
      s7_side_in.nb_neg = s6_nb_neg_ff;
      s7_side_in.a_mag  = s6_a_mag_ff;
      s7_side_in.a_neg  = s6_a_neg_ff;
      s7_side_in.a_zero = s6_a_zero_ff;
      s7_side_in.cplx   = !s6_a_neg_ff && !s6_a_zero_ff && (s6_e_ff != '0)
                        && (s6_sq_ff < s6_t_ff);
      if (s7_side_in.cplx) begin
         s7_q_in = '0;
      end else if (s6_a_neg_ff) begin
         s7_q_in = s6_sq_ff + s6_t_ff;
      end else begin
         s7_q_in = s6_sq_ff - s6_t_ff;
      end
   end

   npz_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s7_valid_ff),
      .in_q      (s7_q_ff),
      .in_side   (s7_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      s10_diff = {1'b0, s9_side_ff.nb_mag} - {1'b0, s9_term_ff};
      if (s10_diff[npz_pkg::NB_W]) begin
         s10_num_in     = s9_term_ff - s9_side_ff.nb_mag;
         s10_num_neg_in = !s9_side_ff.nb_neg;
      end else begin
         s10_num_in     = s10_diff[npz_pkg::NB_W-1:0];
         s10_num_neg_in = s9_side_ff.nb_neg;
      end
   end

   always_comb begin
      s11_side_in.num_neg = s10_num_neg_ff;
      s11_side_in.a_neg   = s10_a_neg_ff;
      s11_side_in.a_zero  = s10_a_zero_ff;
      s11_side_in.cplx    = s10_cplx_ff;
      s11_side_in.ovf     = s10_num_ff >= {1'b0, s10_d_ff, 24'd0};
   end

   npz_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s11_valid_ff),
      .in_num    (s11_num_ff),
      .in_d      (s11_d_ff),
      .in_side   (s11_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   always_comb begin
      fin_neg = (dv_side.ovf || (dv_quo != '0)) && (dv_side.num_neg != dv_side.a_neg);
      if (dv_side.ovf) begin
         fin_mag = fin_neg ? npz_pkg::SAT_NEG_MAG : npz_pkg::SAT_POS;
      end else if (fin_neg && (dv_quo > npz_pkg::SAT_NEG_MAG)) begin
         fin_mag = npz_pkg::SAT_NEG_MAG;
      end else if (!fin_neg && (dv_quo > npz_pkg::SAT_POS)) begin
         fin_mag = npz_pkg::SAT_POS;
      end else begin
         fin_mag = dv_quo;
      end
      if (dv_side.a_zero) begin
         rsp_tdata_in = '0;
         rsp_tuser_in = 1'b1;
      end else begin
         rsp_tdata_in = fin_neg ? npz_pkg::RSP_TDATA_W'(-fin_mag) : fin_mag;
         rsp_tuser_in = dv_side.cplx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         s5_valid_ff   <= 1'b0;
         s6_valid_ff   <= 1'b0;
         s7_valid_ff   <= 1'b0;
         s8_valid_ff   <= 1'b0;
         s9_valid_ff   <= 1'b0;
         s10_valid_ff  <= 1'b0;
         s11_valid_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff   <= req_tvalid;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         s5_valid_ff   <= s4_valid_ff;
         s6_valid_ff   <= s5_valid_ff;
         s7_valid_ff   <= s6_valid_ff;
         s8_valid_ff   <= sq_valid;
         s9_valid_ff   <= s8_valid_ff;
         s10_valid_ff  <= s9_valid_ff;
         s11_valid_ff  <= s10_valid_ff;
         rsp_tvalid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ee_ff  <= s1_ee_in;
         s1_mm_ff  <= s1_mm_in;
         s1_zz_ff  <= s1_zz_in;
         s1_xx_ff  <= s1_xx_in;
         s1_yy_ff  <= s1_yy_in;
         s1_xn_ff  <= s1_xn_in;
         s1_yn_ff  <= s1_yn_in;
         s1_nxx_ff <= s1_nxx_in;
         s1_nyy_ff <= s1_nyy_in;
         s1_lz_ff  <= in_lz;
         s1_e_ff   <= in_e;

         s2_pa_ff  <= s2_pa_in;
         s2_pb_ff  <= s2_pb_in;
         s2_a_ff   <= s2_a_in;
         s2_pt2_ff <= s2_pt2_in;
         s2_lz_ff  <= s1_lz_ff;
         s2_e_ff   <= s1_e_ff;

         s3_app_ff <= s2_pa_ff - s2_pb_ff;
         s3_a_ff   <= s2_a_ff;
         s3_pt2_ff <= s2_pt2_ff;
         s3_lz_ff  <= s2_lz_ff;
         s3_e_ff   <= s2_e_ff;

         s4_app_mag_ff <= s4_app_mag_in;
         s4_app_neg_ff <= s3_app_ff[npz_pkg::APP_W-1];
         s4_a_mag_ff   <= s4_a_mag_in;
         s4_a_neg_ff   <= s3_a_ff[npz_pkg::A_W-1];
         s4_a_zero_ff  <= (s3_a_ff == '0);
         s4_lz_mag_ff  <= s4_lz_mag_in;
         s4_lz_neg_ff  <= s3_lz_ff[npz_pkg::P_W-1];
         s4_pt2_ff     <= s3_pt2_ff;
         s4_e_ff       <= s3_e_ff;

         s5_sq_hh_ff   <= {25'd0, s5_h} * {25'd0, s5_h};
         s5_sq_hl_ff   <= {25'd0, s5_h} * {25'd0, s5_l};
         s5_sq_ll_ff   <= {25'd0, s5_l} * {25'd0, s5_l};
         s5_t_hh_ff    <= {24'd0, s5_ah} * {24'd0, s5_ph};
         s5_t_hl_ff    <= {24'd0, s5_ah} * {24'd0, s5_pl};
         s5_t_lh_ff    <= {24'd0, s5_al} * {25'd0, s5_ph};
         s5_t_ll_ff    <= {24'd0, s5_al} * {25'd0, s5_pl};
         s5_nb_h_ff    <= {25'd0, s4_lz_mag_ff} * {24'd0, s5_h};
         s5_nb_l_ff    <= {25'd0, s4_lz_mag_ff} * {24'd0, s5_l};
         s5_nb_sign_ff <= (s4_lz_neg_ff == s4_app_neg_ff);
         s5_a_mag_ff   <= s4_a_mag_ff;
         s5_a_neg_ff   <= s4_a_neg_ff;
         s5_a_zero_ff  <= s4_a_zero_ff;
         s5_e_ff       <= s4_e_ff;

         s6_sq_ff     <= s6_sq_in;
         s6_t_ff      <= s6_t_in;
         s6_nb_ff     <= s6_nb_in;
         s6_nb_neg_ff <= s5_nb_sign_ff && (s6_nb_in != '0);
         s6_a_mag_ff  <= s5_a_mag_ff;
         s6_a_neg_ff  <= s5_a_neg_ff;
         s6_a_zero_ff <= s5_a_zero_ff;
         s6_e_ff      <= s5_e_ff;

         s7_q_ff    <= s7_q_in;
         s7_side_ff <= s7_side_in;

         s8_term_h_ff <= {25'd0, sq_side.e} * {23'd0, sq_root[49:25]};
         s8_term_l_ff <= {25'd0, sq_side.e} * {23'd0, sq_root[24:0]};
         s8_side_ff   <= sq_side;

         s9_term_ff <= {s8_term_h_ff, 25'd0} + {25'd0, s8_term_l_ff};
         s9_side_ff <= s8_side_ff;

         s10_num_ff     <= s10_num_in;
         s10_num_neg_ff <= s10_num_neg_in;
         s10_d_ff       <= {s9_side_ff.a_mag, 1'b0};
         s10_a_neg_ff   <= s9_side_ff.a_neg;
         s10_a_zero_ff  <= s9_side_ff.a_zero;
         s10_cplx_ff    <= s9_side_ff.cplx;

         s11_num_ff  <= s10_num_ff;
         s11_d_ff    <= s10_d_ff;
         s11_side_ff <= s11_side_in;

         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid_ff)
      else $error("Result valid after reset.");

   a_cplx_needs_positive_a: assert property (@(posedge clock) disable iff (reset)
      s7_valid_ff && s7_side_ff.cplx |-> !s7_side_ff.a_neg && !s7_side_ff.a_zero
                                          && (s7_q_ff == '0))
      else $error("Complex case with a not positive.");

   a_div_start_in_range: assert property (@(posedge clock) disable iff (reset)
      s11_valid_ff && !s11_side_ff.ovf && !s11_side_ff.a_zero
      |-> ({1'b0, s11_num_ff[npz_pkg::NUM_W-1:24]} < {2'b00, s11_d_ff}))
      else $error("Divider start remainder not below divisor.");

   a_stall_holds_pipeline: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s7_q_ff) && $stable(s11_num_ff) && $stable(s1_valid_ff))
      else $error("Pipeline moved while stalled.");
`endif

endmodule

// File: tb/neutrino_pz_from_w_mass_core_test.sv
// Self-checking testbench for the neutrino pz pipeline with a built-in predictor.
`timescale 1ns / 1ps

module neutrino_pz_from_w_mass_core_test;

   typedef struct packed {
      logic [npz_pkg::P_W-1:0] ny;
      logic [npz_pkg::P_W-1:0] nx;
      logic [npz_pkg::P_W-1:0] lz;
      logic [npz_pkg::P_W-1:0] ly;
      logic [npz_pkg::P_W-1:0] lx;
      logic [npz_pkg::E_W-1:0] e;
   } event_type;

   typedef struct packed {
      logic [npz_pkg::QUO_W-1:0] pz;
      logic                      flag;
   } solution_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [npz_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [npz_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_tvalid;
   logic csr_tready;
   logic [npz_pkg::CSR_TDATA_W-1:0] csr_tdata;

   event_type    pending_events[$];
   solution_type expected_solutions[$];
   logic [npz_pkg::M_W-1:0] mass_setting;
   int  error_count = 0;
   bit  quiet;
   int  send_gap;
   int  stall_gap;
   event_type current_event;

   neutrino_pz_from_w_mass_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_tvalid(csr_tvalid), .csr_tready(csr_tready), .csr_tdata(csr_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(logic [127:0] q);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 0;
      hi = 64'd1 << 50;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if ({64'd0, mid} * {64'd0, mid} <= q) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic solution_type solve_pz(event_type ev, logic [npz_pkg::M_W-1:0] mw);
      longint e, lx, ly, lz, nx, ny, m, app, a;
      logic signed [127:0] ew, lzw, appw, aw, absa, pt2, nb, num, term, sq, t, q, quo;
      solution_type s;
      e = ev.e;
      lx = $signed(ev.lx);
      ly = $signed(ev.ly);
      lz = $signed(ev.lz);
      nx = $signed(ev.nx);
      ny = $signed(ev.ny);
      m = mw;
      app = e*e - lz*lz - lx*lx - ly*ly - 2*lx*nx - 2*ly*ny - m*m;
      a = e*e - lz*lz;
      s.flag = 1'b0;
      if (a == 0) begin
         s.pz = '0;
         s.flag = 1'b1;
         return s;
      end
      ew = e;
      lzw = lz;
      appw = app;
      aw = a;
      absa = (aw < 0) ? -aw : aw;
      pt2 = nx*nx + ny*ny;
      nb = -(lzw * appw);
      num = nb;
      q = 0;
      if (e != 0) begin
         sq = appw * appw;
         t = 4 * absa * pt2;
         if (aw < 0) q = sq + t;
         else if (sq < t) s.flag = 1'b1;
         else q = sq - t;
         if (!s.flag) begin
            term = ew * $signed({64'd0, root_floor(q)});
            num = (nb >= 0) ? nb - term : nb + term;
         end
      end
      quo = num / (2 * aw);
      if (quo > 8388607) s.pz = npz_pkg::SAT_POS;
      else if (quo < -8388608) s.pz = npz_pkg::SAT_NEG_MAG;
      else s.pz = quo[npz_pkg::QUO_W-1:0];
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_solutions.push_back(solve_pz(current_event, mass_setting));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 6);
            req_tvalid <= 1'b0;
         end else if (pending_events.size() > 0) begin
            current_event = pending_events.pop_front();
            req_tdata <= {1'b0, current_event};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_gap <= 0;
      end else if (stall_gap > 0) begin
         stall_gap <= stall_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_gap <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      solution_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_solutions.size() == 0) begin
            $error("unexpected result pz=%0d flag=%0d", $signed(rsp_tdata), rsp_tuser);
            error_count++;
         end else begin
            want = expected_solutions.pop_front();
            if (rsp_tdata !== want.pz) begin
               $error("neutrino_pz expected %0d actual %0d", $signed(want.pz),
                  $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tuser !== want.flag) begin
               $error("complex_flag expected %0d actual %0d", want.flag, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   function automatic event_type random_event();
      event_type ev;
      logic [159:0] noise;
      int kind;
      kind = $urandom_range(0, 9);
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      ev = noise[142:0];
      if (kind < 6) begin
         ev.lx = 24'($urandom_range(0, 65535) - 32768);
         ev.ly = 24'($urandom_range(0, 65535) - 32768);
         ev.lz = 24'($urandom_range(0, 131071) - 65536);
         ev.nx = 24'($urandom_range(0, 65535) - 32768);
         ev.ny = 24'($urandom_range(0, 65535) - 32768);
         ev.e = 23'($urandom_range(0, 40000)) + ($signed(ev.lz) < 0 ?
            23'(-$signed(ev.lz)) : 23'(ev.lz));
         if (kind == 0) ev.e = $signed(ev.lz) < 0 ? 23'(-$signed(ev.lz)) : 23'(ev.lz);
      end else if (kind == 6) begin
         ev.e = $signed(ev.lz) < 0 ? 23'(-$signed(ev.lz)) : 23'(ev.lz);
      end
      return ev;
   endfunction

   task automatic wait_drained();
      while (pending_events.size() > 0 || req_tvalid || expected_solutions.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_mass(logic [npz_pkg::M_W-1:0] value);
      @(posedge clock);
      csr_tdata <= {1'($urandom), value};
      csr_tvalid <= 1'b1;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      mass_setting = value;
   endtask

   task automatic add_event(logic [npz_pkg::E_W-1:0] e, logic [npz_pkg::P_W-1:0] lx,
      logic [npz_pkg::P_W-1:0] ly, logic [npz_pkg::P_W-1:0] lz,
      logic [npz_pkg::P_W-1:0] nx, logic [npz_pkg::P_W-1:0] ny);
      pending_events.push_back({ny, nx, lz, ly, lx, e});
   endtask

   initial begin
      logic [npz_pkg::M_W-1:0] masses[5];
      reset = 1'b1;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      mass_setting = npz_pkg::W_MASS_RESET;
      quiet = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_event(0, 0, 0, 0, 0, 0);
      add_event(23'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      add_event(23'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
      add_event(23'h7FFFFF, 0, 0, 24'h7FFFFF, 0, 0);
      add_event(23'h7FFFFF, 0, 0, 24'h800001, 24'h001000, 0);
      add_event(0, 24'h001000, 0, 24'h800000, 24'h7FFFFF, 24'h000100);
      add_event(0, 24'h000100, 24'h000200, 24'h000300, 24'h000400, 24'h000500);
      add_event(23'd20000, 24'd3000, 24'd1000, 0, 24'd5000, 24'hFFF000);
      add_event(23'd20000, 24'd3000, 24'd1000, 0, 24'd500000, 24'hF00000);
      add_event(23'd1000, 24'd100, 0, 24'd999, 24'h7FFFFF, 24'h7FFFFF);
      add_event(23'd1000, 24'd100, 0, 24'hFFFC19, 24'h800000, 24'h800000);
      add_event(23'd30000, 24'd10000, 24'hFFD8F0, 24'd15000, 24'hFFC000, 24'd9000);
      add_event(23'd12, 24'd5, 24'd5, 24'd3, 24'd2, 24'd1);
      add_event(23'h7FFFFF, 24'h7FFFFF, 24'h800000, 0, 24'h800000, 24'h7FFFFF);

      masses[0] = npz_pkg::W_MASS_RESET;
      masses[1] = 0;
      masses[2] = 23'h7FFFFF;
      masses[3] = 23'($urandom);
      masses[4] = 23'd20582;
      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) write_mass(masses[phase]);
         if (phase == 4) quiet = 1'b1;
         for (int i = 0; i < 80; i++) pending_events.push_back(random_event());
         wait_drained();
      end

      if (error_count == 0) $display("neutrino_pz_from_w_mass_core_test: clean");
      else $display("neutrino_pz_from_w_mass_core_test: errors");
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("neutrino_pz_from_w_mass_core_test: errors");
      $finish;
   end

endmodule
